// ===== hdl/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

	localparam logic [31:0] K_00_19 = 32'h5A827999;
	localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
	localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
	localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

	localparam logic [31:0] H_INIT0 = 32'h67452301;
	localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
	localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
	localparam logic [31:0] H_INIT3 = 32'h10325476;
	localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

	localparam logic [7:0] PAD_MARK     = 8'h80;
	localparam logic [5:0] LEN_POS      = 6'd56;
	localparam logic [6:0] LAST_ROUND   = 7'd79;
	localparam logic [63:0] BYTE_BITS   = 64'd8;

	typedef logic [31:0] word_t;

	// Round function plus constant, selected by round number.
	function automatic logic [63:0] round_fk(input logic [6:0] rnd, input word_t b,
			input word_t c, input word_t d);
		word_t f;
		word_t k;
		if (rnd < 7'd20) begin
			f = (b & (c ^ d)) ^ d;
			k = K_00_19;
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
			k = K_20_39;
		end else if (rnd < 7'd60) begin
			f = ((b | c) & d) | (b & c);
			k = K_40_59;
		end else begin
			f = b ^ c ^ d;
			k = K_60_79;
		end
		return {f, k};
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sha1_hash_engine.sv =====
`default_nettype none

// SHA-1 engine fed one message byte per request. A request with has_byte set
// appends message_byte; a request with last set (with or without a byte) pads
// the message, finishes it and produces one digest of five big-endian words,
// after which the engine starts a fresh message. A byte that does not
// complete a 64-byte block is accepted without stalling. Completing a block
// runs the compression on a single shared round unit, one round per cycle,
// then folds the result into the chaining value, with in_ready low
// throughout. A last request then writes its padding bytes (9 to 72) one by
// one, runs one or two more compressions and loads the output register. The
// digest waits in that register while new bytes are accepted; only the next
// digest waits for it to be taken.
module sha1_hash_engine import sha1_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  message_byte,
	input  wire logic        has_byte,
	input  wire logic        last,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word0,
	output logic [31:0]      digest_word1,
	output logic [31:0]      digest_word2,
	output logic [31:0]      digest_word3,
	output logic [31:0]      digest_word4
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_COMP = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_PAD  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	// Padding phases.
	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_ZERO = 2'd1;
	localparam logic [1:0] PAD_LEN  = 2'd2;

	logic [2:0]  state_q;
	logic [1:0]  pad_q;
	logic        first_q;       // next pad byte is the 0x80 marker
	logic [5:0]  pos_q;         // byte index within the block
	logic [63:0] bitlen_q;
	logic [63:0] len_q;         // length being appended, shifted out MSB first
	logic [23:0] acc_q;         // bytes of the word being packed
	logic [6:0]  round_q;

	word_t       sched_q [16];  // message schedule window, sched_q[0] is W[t]
	word_t       chain_q [5];
	word_t       a_q, b_q, c_q, d_q, e_q;

	logic        out_valid_q;
	word_t       digest_q [5];

	logic        in_fire;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic        wr_wrap;
	logic [5:0]  pos_next;
	logic        push_en;
	word_t       push_word;
	logic [63:0] fk;
	word_t       round_t;
	logic        fin_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign digest_word0 = digest_q[0];
	assign digest_word1 = digest_q[1];
	assign digest_word2 = digest_q[2];
	assign digest_word3 = digest_q[3];
	assign digest_word4 = digest_q[4];

	// Byte write: a message byte from a request, or a padding byte.
	always_comb begin
		wr_en   = 1'b0;
		wr_byte = message_byte;
		if (state_q == ST_IDLE) begin
			wr_en = in_fire && has_byte;
		end else if (state_q == ST_PAD) begin
			wr_en = 1'b1;
			if (pad_q == PAD_LEN) begin
				wr_byte = len_q[63:56];
			end else if (first_q) begin
				wr_byte = PAD_MARK;
			end else begin
				wr_byte = 8'h00;
			end
		end
	end

	assign pos_next = pos_q + 6'd1;
	assign wr_wrap  = wr_en && (pos_q == 6'd63);

	// Round datapath: one SHA-1 round per cycle.
	assign fk      = round_fk(round_q, b_q, c_q, d_q);
	assign round_t = {a_q[26:0], a_q[31:27]} + fk[63:32] + e_q + fk[31:0] + sched_q[0];

	// Schedule window input: a packed word while filling, the expanded
	// word W[t+16] while compressing.
	always_comb begin
		push_en   = 1'b0;
		push_word = {acc_q, wr_byte};
		if (state_q == ST_COMP) begin
			push_en   = 1'b1;
			push_word = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
			push_word = {push_word[30:0], push_word[31]};
		end else if (wr_en && (pos_q[1:0] == 2'd3)) begin
			push_en = 1'b1;
		end
	end

	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Schedule window and byte packing; no reset needed.
	always_ff @(posedge clk) begin
		if (push_en) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= push_word;
		end
		if (wr_en) begin
			acc_q <= {acc_q[15:0], wr_byte};
		end
	end

	// Working variables: load from the chain on block start, advance per round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			e_q <= '0;
		end else if (wr_wrap) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_COMP) begin
			a_q <= round_t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Output register; holds the digest until it is taken.
	always_ff @(posedge clk) begin
		if (fin_load) begin
			for (int i = 0; i < 5; i++) begin
				digest_q[i] <= chain_q[i];
			end
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pad_q       <= PAD_NONE;
			first_q     <= 1'b0;
			pos_q       <= '0;
			bitlen_q    <= '0;
			len_q       <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
			chain_q[0]  <= H_INIT0;
			chain_q[1]  <= H_INIT1;
			chain_q[2]  <= H_INIT2;
			chain_q[3]  <= H_INIT3;
			chain_q[4]  <= H_INIT4;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (wr_en) begin
				pos_q <= pos_next;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (last) begin
							// latch the final length and start a new count
							len_q    <= has_byte ? bitlen_q + BYTE_BITS : bitlen_q;
							bitlen_q <= '0;
							pad_q    <= PAD_ZERO;
							first_q  <= 1'b1;
						end else if (has_byte) begin
							bitlen_q <= bitlen_q + BYTE_BITS;
						end
						if (wr_wrap) begin
							round_q <= '0;
							state_q <= ST_COMP;
						end else if (last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (pad_q == PAD_LEN) begin
						len_q <= {len_q[55:0], 8'h00};
					end else if (!wr_wrap && (pos_next == LEN_POS)) begin
						pad_q <= PAD_LEN;
					end
					if (wr_wrap) begin
						round_q <= '0;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					round_q <= round_q + 7'd1;
					if (round_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					case (pad_q)
						PAD_NONE: state_q <= ST_IDLE;
						PAD_ZERO: state_q <= ST_PAD;
						PAD_LEN:  state_q <= ST_FIN;
						default:  state_q <= ST_IDLE;
					endcase
				end
				ST_FIN: begin
					// hand off the digest and reload the initial hash
					if (fin_load) begin
						chain_q[0] <= H_INIT0;
						chain_q[1] <= H_INIT1;
						chain_q[2] <= H_INIT2;
						chain_q[3] <= H_INIT3;
						chain_q[4] <= H_INIT4;
						pad_q      <= PAD_NONE;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_sha1_hash_engine.sv =====
`default_nettype none

module tb_sha1_hash_engine import sha1_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 2500;  // receiver hold-off while the burst is offered
	localparam int IDLE_PCT    = 32;    // chance of an idle cycle on either side
	localparam int DRAIN_WAIT  = 300;   // quiet stretch after every digest is back
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_REQS = 1000;
	localparam int CALM_REQS   = 300;

	// One byte request as the driver offers it.
	typedef struct packed {
		logic [7:0] data;
		logic       carries;
		logic       ends;
	} req_t;

	typedef struct packed {
		word_t h0;
		word_t h1;
		word_t h2;
		word_t h3;
		word_t h4;
	} digest_t;

	logic        clk;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  message_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        last = 1'b0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;

	sha1_hash_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.message_byte (message_byte),
		.has_byte     (has_byte),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digest_word0 (digest_word0),
		.digest_word1 (digest_word1),
		.digest_word2 (digest_word2),
		.digest_word3 (digest_word3),
		.digest_word4 (digest_word4)
	);

	// Requests waiting for the driver, and digests waiting for the engine.
	req_t    byte_req_q[$];
	digest_t digest_q[$];
	req_t    next_req;
	digest_t want;

	// Mirror of the hash state, advanced on every accepted request.
	word_t       hash_state[5];
	word_t       sched[16];
	logic [5:0]  fill_pos;
	logic [63:0] msg_bits;

	// Knobs calm and hold_arm come from the initial block; hold state is the receiver's.
	bit calm = 1'b0;
	bit hold_arm = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	int queued_reqs = 0;
	int reqs_taken = 0;
	int digests_seen = 0;
	int mismatches = 0;
	int stall_run = 0;
	int stall_max = 0;
	int cycle_cnt = 0;
	int longest_msg = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void load_initial_hash();
		hash_state[0] = H_INIT0;
		hash_state[1] = H_INIT1;
		hash_state[2] = H_INIT2;
		hash_state[3] = H_INIT3;
		hash_state[4] = H_INIT4;
		msg_bits = '0;
		fill_pos = '0;
	endfunction

	// Run the 80 rounds over the current block; the schedule is rewritten in place.
	function automatic void fold_block();
		word_t a, b, c, d, e, f, k, t, x;
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16) begin
				x = sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^ sched[(r + 2) % 16] ^
					sched[r % 16];
				sched[r % 16] = {x[30:0], x[31]};
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_00_19;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_20_39;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_40_59;
			end else begin
				f = b ^ c ^ d;
				k = K_60_79;
			end
			t = {a[26:0], a[31:27]} + f + e + k + sched[r % 16];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	function automatic void append_byte(logic [7:0] v);
		sched[fill_pos[5:2]][(3 - fill_pos[1:0]) * 8 +: 8] = v;
		fill_pos = fill_pos + 6'd1;
		if (fill_pos == 6'd0) begin
			fold_block();
		end
	endfunction

	// Take one request; a closing request pads the message and queues its digest.
	function automatic void absorb_request(logic [7:0] data, logic carries, logic ends);
		logic [63:0] len;
		if (carries) begin
			msg_bits += BYTE_BITS;
			append_byte(data);
		end
		if (ends) begin
			len = msg_bits;
			append_byte(PAD_MARK);
			while (fill_pos != LEN_POS) begin
				append_byte(8'h00);
			end
			for (int i = 0; i < 8; i++) begin
				append_byte(8'(len >> (56 - 8 * i)));
			end
			digest_q.push_back({hash_state[0], hash_state[1], hash_state[2],
				hash_state[3], hash_state[4]});
			load_initial_hash();
		end
	endfunction

	// Favor the all-zero and all-one bytes now and then.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return 8'h00;
		end else if (r < 20) begin
			return 8'hFF;
		end
		return 8'($urandom);
	endfunction

	function automatic void push_req(logic [7:0] data, logic carries, logic ends);
		byte_req_q.push_back('{data: data, carries: carries, ends: ends});
		if (carries || ends) begin
			queued_reqs++;
		end
	endfunction

	// Queue one whole message with a few ignored requests mixed in. The closing
	// request either carries the final byte or comes on its own without one.
	function automatic void queue_message(int n);
		bool_loop: for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 5) begin
				push_req(pick_byte(), 1'b0, 1'b0);
			end
			push_req(pick_byte(), 1'b1, (i == n - 1) && $urandom_range(0, 1));
		end
		if (n == 0 || !byte_req_q[$].ends) begin
			push_req(pick_byte(), 1'b0, 1'b1);
		end
		if (n > longest_msg) begin
			longest_msg = n;
		end
	endfunction

	// Mostly short messages, plenty around the 55/56/64 byte padding boundaries,
	// and a few that span several blocks.
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return $urandom_range(0, 20);
		end else if (r < 75) begin
			return $urandom_range(52, 68);
		end else if (r < 90) begin
			return $urandom_range(110, 136);
		end
		return $urandom_range(170, 260);
	endfunction

	// Block until every request is accepted and every digest has come back.
	task automatic wait_drained();
		@(negedge clk);
		while (byte_req_q.size() != 0 || in_valid || digest_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Driver: predict on acceptance, then offer the next request or idle.
	// Valid and payload only move when nothing is on offer or the offer was taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_request(message_byte, has_byte, last);
				reqs_taken++;
			end
			// track how long the engine keeps the input stalled
			if (in_valid && !in_ready) begin
				stall_run++;
				if (stall_run > stall_max) begin
					stall_max = stall_run;
				end
			end else begin
				stall_run = 0;
			end
			if (!in_valid || in_ready) begin
				if (byte_req_q.size() != 0 &&
						(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_req = byte_req_q.pop_front();
					message_byte <= next_req.data;
					has_byte     <= next_req.carries;
					last         <= next_req.ends;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each digest against the oldest prediction, then decide
	// ready for the next cycle. Once armed, hold off for a long fixed stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				digests_seen++;
				if (digest_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected digest %h %h %h %h %h", digest_word0,
							digest_word1, digest_word2, digest_word3, digest_word4);
					end
				end else begin
					want = digest_q.pop_front();
					if (digest_word0 !== want.h0 || digest_word1 !== want.h1 ||
							digest_word2 !== want.h2 || digest_word3 !== want.h3 ||
							digest_word4 !== want.h4) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("digest %0d mismatch: expected %h %h %h %h %h",
								digests_seen, want.h0, want.h1, want.h2, want.h3,
								want.h4);
							$display("  actual %h %h %h %h %h", digest_word0,
								digest_word1, digest_word2, digest_word3, digest_word4);
						end
					end
				end
			end
			if (hold_arm && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: a hung engine ends the run as a failure.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digests outstanding", cycle_cnt,
				digest_q.size());
			$display("tb_sha1_hash_engine: done, errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 16; i++) begin
			sched[i] = '0;
		end
		load_initial_hash();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty messages, one-byte messages with extreme bytes, a three-byte
		// message, "abc" closed by a request without a byte, and ignored requests.
		push_req(8'h00, 1'b0, 1'b1);
		push_req(8'hFF, 1'b1, 1'b1);
		push_req(8'h61, 1'b1, 1'b0);
		push_req(8'h62, 1'b1, 1'b0);
		push_req(8'h63, 1'b1, 1'b0);
		push_req(8'hFF, 1'b0, 1'b1);
		push_req(8'hFF, 1'b0, 1'b0);
		push_req(8'h00, 1'b1, 1'b1);
		push_req(8'hA5, 1'b0, 1'b0);
		push_req(8'h5A, 1'b1, 1'b0);
		push_req(8'h80, 1'b1, 1'b0);
		push_req(8'h7F, 1'b1, 1'b1);
		push_req(8'h00, 1'b0, 1'b1);
		push_req(8'h01, 1'b1, 1'b0);
		push_req(8'hFE, 1'b0, 1'b1);

		// Pause the sender until every digest is back.
		wait_drained();

		// Burst of tiny messages against a receiver that holds off: the output
		// register fills and the engine must stall its input.
		hold_arm = 1'b1;
		for (int i = 0; i < 8; i++) begin
			queue_message($urandom_range(0, 3));
		end
		wait_drained();

		// Random messages; the first stretch runs with no idling on either side.
		calm = 1'b1;
		while (queued_reqs < CALM_REQS) begin
			queue_message(pick_len());
		end
		@(negedge clk);
		while (byte_req_q.size() != 0) begin
			@(negedge clk);
		end
		calm = 1'b0;
		while (queued_reqs < CALM_REQS + RANDOM_REQS) begin
			queue_message(pick_len());
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("covered %0d byte requests, %0d digests checked, longest message %0d bytes",
			reqs_taken, digests_seen, longest_msg);
		$display("input stalled up to %0d cycles; receiver held off %0d cycles once",
			stall_max, HOLD_CYCLES);
		if (mismatches == 0 && digest_q.size() == 0) begin
			$display("tb_sha1_hash_engine: done, clean");
		end else begin
			$display("%0d digest mismatches", mismatches);
			$display("tb_sha1_hash_engine: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/sha1_pkg.sv
hdl/sha1_hash_engine.sv
dv/tb_sha1_hash_engine.sv
